// ----- design/tdmp_pkg.sv -----
package tdmp_pkg;

  localparam int P_W = 20;
  localparam int Y_W = 60;
  localparam int S_W = 61;  // masked alpha and beta sum width
  localparam logic [P_W-1:0] PRIME_RESET = 20'd1048573;
  localparam logic [P_W-1:0] P_MIN = 20'd2;

  typedef struct packed {
    logic [Y_W-1:0] linear_value;
    logic [P_W-1:0] alpha_offset;
    logic           alpha_mask_bit;
    logic [P_W-1:0] beta_offset;
    logic           beta_mask_bit;
    logic           last_item;
  } in_item_t;

  typedef struct packed {
    logic [Y_W-1:0] packed_tag;
    logic [1:0]     tag_bits;
    logic           last_tag;
  } out_item_t;

  // sideband through the first split
  typedef struct packed {
    logic [P_W-1:0] alpha_offset;
    logic           alpha_mask_bit;
    logic [P_W-1:0] beta_offset;
    logic           beta_mask_bit;
    logic           last_item;
  } side1_t;

  // sideband through the second split
  typedef struct packed {
    side1_t         s1;
    logic [P_W-1:0] rem;
  } side2_t;

  // sideband through the masking divide
  typedef struct packed {
    logic           alpha_mask_bit;
    logic           beta_mask_bit;
    logic [P_W-1:0] rem;
    logic           last_item;
  } side3_t;

endpackage

// ----- design/tdmp_stream_if.sv -----
interface tdmp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/tdmp_div.sv -----
// Restoring divider, one quotient bit per pipeline stage.
module tdmp_div #(
  parameter int W  = 60,
  parameter int SW = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic [tdmp_pkg::P_W-1:0] p,
  input  logic                    in_valid,
  input  logic [W-1:0]            dividend,
  input  logic [SW-1:0]           side_in,
  output logic                    out_valid,
  output logic [W-1:0]            quotient,
  output logic [tdmp_pkg::P_W-1:0] remainder,
  output logic [SW-1:0]           side_out
);

  localparam int PW = tdmp_pkg::P_W;

  logic [W-1:0]  vld_r;
  logic [PW-1:0] rem_r [W];
  logic [W-1:0]  qd_r  [W];
  logic [SW-1:0] sd_r  [W];

  for (genvar k = 0; k < W; k++) begin : g_st
    logic [PW-1:0] rem_i;
    logic [W-1:0]  qd_i;
    logic [SW-1:0] sd_i;
    logic          v_i;
    logic [PW:0]   trial;
    logic          ge;
    logic [PW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign qd_i  = dividend;
      assign sd_i  = side_in;
      assign v_i   = in_valid;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign qd_i  = qd_r[k-1];
      assign sd_i  = sd_r[k-1];
      assign v_i   = vld_r[k-1];
    end

    // shift in next dividend bit, subtract if it fits
    assign trial   = {rem_i, qd_i[W-1]};
    assign ge      = (trial >= {1'b0, p});
    assign rem_nxt = ge ? PW'(trial - {1'b0, p}) : trial[PW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        qd_r[k]  <= {qd_i[W-2:0], ge};
        sd_r[k]  <= sd_i;
      end
    end
  end

  assign out_valid = vld_r[W-1];
  assign quotient  = qd_r[W-1];
  assign remainder = rem_r[W-1];
  assign side_out  = sd_r[W-1];

endmodule

// ----- design/tdmp_pack.sv -----
// Packs alpha_frac*p^2 + beta_frac*p + r in three stages (Horner form).
module tdmp_pack (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic [tdmp_pkg::P_W-1:0] p,
  input  logic                     in_valid,
  input  logic [tdmp_pkg::P_W-1:0] a_frac,
  input  logic [tdmp_pkg::P_W-1:0] b_frac,
  input  logic                     a_q0,
  input  logic                     b_q0,
  input  tdmp_pkg::side3_t         side,
  output logic                     out_valid,
  output tdmp_pkg::out_item_t      out_item
);

  localparam int PW = tdmp_pkg::P_W;

  logic            v1_r, v2_r, v3_r;
  logic [2*PW-1:0] t_r;
  logic [2*PW-1:0] hi_r, lo_r;
  logic [PW-1:0]   r1_r, r2_r;
  logic [1:0]      bits1_r, bits2_r;
  logic            last1_r, last2_r;
  tdmp_pkg::out_item_t item_r;
  logic [2*PW-1:0] t_nxt;
  logic [2*PW-1:0] hi_nxt, lo_nxt;
  logic [tdmp_pkg::Y_W-1:0] tag_nxt;

  assign t_nxt   = (2*PW)'(a_frac) * (2*PW)'(p) + (2*PW)'(b_frac);
  assign hi_nxt  = (2*PW)'(t_r[2*PW-1:PW]) * (2*PW)'(p);
  assign lo_nxt  = (2*PW)'(t_r[PW-1:0]) * (2*PW)'(p);
  assign tag_nxt = {hi_r, {PW{1'b0}}} + tdmp_pkg::Y_W'(lo_r) + tdmp_pkg::Y_W'(r2_r);

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= t_nxt;
      r1_r    <= side.rem;
      bits1_r <= {a_q0 ^ side.alpha_mask_bit, b_q0 ^ side.beta_mask_bit};
      last1_r <= side.last_item;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
      r2_r    <= r1_r;
      bits2_r <= bits1_r;
      last2_r <= last1_r;
      item_r.packed_tag <= tag_nxt;
      item_r.tag_bits   <= bits2_r;
      item_r.last_tag   <= last2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_item  = item_r;

endmodule

// ----- design/two_digit_masked_mac_tag_packer_top.sv -----
// Two-digit masked MAC tag packer.
// in_ch carries linear_value y, the two offsets, two mask bits and last_item.
// out_ch returns packed_tag, tag_bits and last_tag, one result per item, in
// order. cfg_ch writes the modulus p; it is always ready and must only be
// written while nothing is in flight. A modulus of 0 or 1 acts as 2.
// 60 stages split y by p, 60 stages split the quotient into alpha and beta,
// 61 stages reduce the masked digits and 3 stages pack.
// One item per cycle is accepted while the output is not stalled; each divider
// stage is one step of a restoring divider, so the divider depth sets most of the latency.
// Reset clears all valid bits and loads p = 1048573.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ch.ready drops; nothing is lost or repeated, and bubbles in the
// pipeline keep moving while the output register is empty.
module two_digit_masked_mac_tag_packer_top (
  input  logic clk,
  input  logic rst_n,
  tdmp_stream_if.sink   in_ch,
  tdmp_stream_if.sink   cfg_ch,
  tdmp_stream_if.source out_ch
);

  localparam int PW = tdmp_pkg::P_W;
  localparam int YW = tdmp_pkg::Y_W;
  localparam int SW = tdmp_pkg::S_W;

  logic [PW-1:0] prime_r;
  logic [PW-1:0] p_eff;
  logic          en;

  tdmp_pkg::in_item_t in_item;
  tdmp_pkg::side1_t   s1_in, s1_out;
  tdmp_pkg::side2_t   s2_in, s2_out;
  tdmp_pkg::side3_t   s3_in, s3_out;

  logic          v1, v2, v3;
  logic [YW-1:0] q1, alpha;
  logic [PW-1:0] r1, beta;
  logic [SW-1:0] sum_a, sum_b, qa, qb;
  logic [PW-1:0] a_frac, b_frac;
  logic          unused_v;
  logic [0:0]    unused_sd;

  // modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= tdmp_pkg::PRIME_RESET;
    end else if (cfg_ch.valid) begin
      prime_r <= cfg_ch.data;
    end
  end
  assign cfg_ch.ready = 1'b1;
  assign p_eff = (prime_r < tdmp_pkg::P_MIN) ? tdmp_pkg::P_MIN : prime_r;

  // pipeline advances unless a result is held at the output
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign in_item     = in_ch.data;

  assign s1_in.alpha_offset   = in_item.alpha_offset;
  assign s1_in.alpha_mask_bit = in_item.alpha_mask_bit;
  assign s1_in.beta_offset    = in_item.beta_offset;
  assign s1_in.beta_mask_bit  = in_item.beta_mask_bit;
  assign s1_in.last_item      = in_item.last_item;

  // y -> q, r
  tdmp_div #(.W(YW), .SW($bits(tdmp_pkg::side1_t))) u_div_y (
    .clk, .rst_n, .en, .p(p_eff),
    .in_valid(in_ch.valid), .dividend(in_item.linear_value), .side_in(s1_in),
    .out_valid(v1), .quotient(q1), .remainder(r1), .side_out(s1_out)
  );

  assign s2_in.s1  = s1_out;
  assign s2_in.rem = r1;

  // q -> alpha, beta
  tdmp_div #(.W(YW), .SW($bits(tdmp_pkg::side2_t))) u_div_q (
    .clk, .rst_n, .en, .p(p_eff),
    .in_valid(v1), .dividend(q1), .side_in(s2_in),
    .out_valid(v2), .quotient(alpha), .remainder(beta), .side_out(s2_out)
  );

  // masked digits
  assign sum_a = SW'(alpha) + SW'(s2_out.s1.alpha_offset);
  assign sum_b = SW'(beta) + SW'(s2_out.s1.beta_offset);
  assign s3_in.alpha_mask_bit = s2_out.s1.alpha_mask_bit;
  assign s3_in.beta_mask_bit  = s2_out.s1.beta_mask_bit;
  assign s3_in.rem            = s2_out.rem;
  assign s3_in.last_item      = s2_out.s1.last_item;

  tdmp_div #(.W(SW), .SW($bits(tdmp_pkg::side3_t))) u_div_a (
    .clk, .rst_n, .en, .p(p_eff),
    .in_valid(v2), .dividend(sum_a), .side_in(s3_in),
    .out_valid(v3), .quotient(qa), .remainder(a_frac), .side_out(s3_out)
  );

  tdmp_div #(.W(SW), .SW(1)) u_div_b (
    .clk, .rst_n, .en, .p(p_eff),
    .in_valid(v2), .dividend(sum_b), .side_in(1'b0),
    .out_valid(unused_v), .quotient(qb), .remainder(b_frac), .side_out(unused_sd)
  );

  tdmp_pack u_pack (
    .clk, .rst_n, .en, .p(p_eff),
    .in_valid(v3), .a_frac, .b_frac, .a_q0(qa[0]), .b_q0(qb[0]), .side(s3_out),
    .out_valid(out_ch.valid), .out_item(out_ch.data)
  );

endmodule

// ----- design/tdmp_checker.sv -----
module tdmp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input tdmp_pkg::out_item_t out_data
);

  // input is only refused while a result is held
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input refused without output stall");

  // a free output side always opens the input
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input closed while output free");

  // no result right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("held result changed");

endmodule

bind two_digit_masked_mac_tag_packer_top tdmp_checker u_tdmp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);
